// ----- rtl/assert_macros.svh -----
// Assertion helpers for the tilt block filter RTL.
// Expects clk and rst in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, held off during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication checked on every rising edge, held off during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/acb_pkg.sv -----
// Shared types, codes and tables for the accelerometer tilt block filter.
// No dependencies.
`default_nettype none
package acb_pkg;

  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_GX   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_GY   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_GZ   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_CAL  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_B0   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_B1   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_A1   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_B2   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_A2   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_FILT = 4'd9;

  localparam logic [2:0] REG_CAL_X  = 3'd0;
  localparam logic [2:0] REG_CAL_Y  = 3'd1;
  localparam logic [2:0] REG_CAL_Z  = 3'd2;
  localparam logic [2:0] REG_FILT_X = 3'd3;
  localparam logic [2:0] REG_FILT_Y = 3'd4;
  localparam logic [2:0] REG_FILT_Z = 3'd5;

  localparam int CORDIC_STEPS = 17;
  localparam int SQRT_STEPS = 24;

  typedef struct packed {
    logic              run;
    logic [STEP_W-1:0] step;
    logic              last;
  } lane_ctl_t;

  typedef enum logic [2:0] {S_IDLE, S_LANE, S_PITCH, S_ROLL, S_HOLD} top_state_t;
  typedef enum logic [2:0] {T_IDLE, T_SQA, T_SQB, T_SQRT, T_CHK, T_COR, T_FIN} tilt_state_t;

  function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
    if (v > 36'sd32767) return 16'sh7fff;
    else if (v < -36'sd32768) return 16'sh8000;
    else return v[15:0];
  endfunction

  // atan(2^-i) in degrees, scaled 2^16
  function automatic logic signed [24:0] atan_entry(input logic [4:0] i);
    case (i)
      5'd0:    return 25'sd2949120;
      5'd1:    return 25'sd1740967;
      5'd2:    return 25'sd919879;
      5'd3:    return 25'sd466945;
      5'd4:    return 25'sd234379;
      5'd5:    return 25'sd117304;
      5'd6:    return 25'sd58666;
      5'd7:    return 25'sd29335;
      5'd8:    return 25'sd14668;
      5'd9:    return 25'sd7334;
      5'd10:   return 25'sd3667;
      5'd11:   return 25'sd1833;
      5'd12:   return 25'sd917;
      5'd13:   return 25'sd458;
      5'd14:   return 25'sd229;
      5'd15:   return 25'sd115;
      5'd16:   return 25'sd57;
      default: return 25'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

// ----- rtl/acb_intf.sv -----
// Handshake channel interfaces: raw samples in, tilt angles out.
// No dependencies.
`default_nettype none
interface acb_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         new_data_flags;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;
  modport source (output valid, new_data_flags, raw_x, raw_y, raw_z, input ready);
  modport sink (input valid, new_data_flags, raw_x, raw_y, raw_z, output ready);
endinterface

interface acb_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] pitch_deg;
  logic signed [14:0] roll_deg;
  modport source (output valid, pitch_deg, roll_deg, input ready);
  modport sink (input valid, pitch_deg, roll_deg, output ready);
endinterface
`default_nettype wire

// ----- rtl/accel_tilt_block_filter.sv -----
// Accelerometer tilt block filter. Each sample with nonzero new-data flags is
// calibrated and filtered per axis in three parallel lanes sharing one step
// sequencer, at most one multiply-accumulate per step: a sample holds off the
// input through acceptance and ten lane steps; zero-flag samples are taken and dropped.
// After every BLOCK_LEN-th flagged sample the merge stage computes pitch then roll,
// each a 24-step square root and a 17-step CORDIC (both skipped for a zero
// numerator, CORDIC skipped for a zero magnitude), then registers the result.
// The next sample is accepted once that result is loaded into the output,
// while it waits to be taken. The biquad runs sample by sample, so filter
// coefficients must stay unchanged while a block is part-filled.
// Depends on acb_pkg, acb_intf, acb_lane, acb_tilt and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module accel_tilt_block_filter #(
  parameter int BLOCK_LEN = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  acb_in_if.sink      samples,
  acb_out_if.source   angles
);
  import acb_pkg::*;

  localparam int CNT_W = $clog2(BLOCK_LEN);

  top_state_t state, state_next;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  cnt;
  logic              last, wait_tilt;
  logic signed [15:0] raw_x, raw_y, raw_z, fx, fy, fz;
  logic [63:0] cal_x, cal_y, cal_z;
  logic [59:0] co_x, co_y, co_z;
  lane_ctl_t   ctl;
  logic        tilt_start, tilt_busy, tilt_done;
  logic signed [16:0] t_num;
  logic signed [15:0] t_a, t_b;
  logic signed [14:0] t_angle, pitch_r, roll_r;
  logic        load_out;

  assign last      = (cnt == CNT_W'(BLOCK_LEN - 1));
  assign ctl.run   = (state == S_LANE);
  assign ctl.step  = step;
  assign ctl.last  = last;
  assign samples.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_x <= '0; cal_y <= '0; cal_z <= '0;
      co_x  <= '0; co_y  <= '0; co_z  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAL_X:  cal_x <= cfg_data;
        REG_CAL_Y:  cal_y <= cfg_data;
        REG_CAL_Z:  cal_z <= cfg_data;
        REG_FILT_X: co_x  <= cfg_data[59:0];
        REG_FILT_Y: co_y  <= cfg_data[59:0];
        REG_FILT_Z: co_z  <= cfg_data[59:0];
        default: ;
      endcase
    end
  end

  acb_lane u_lane_x (.clk, .rst, .ctl, .cal_row(cal_x), .coeffs(co_x),
                     .raw_x, .raw_y, .raw_z, .filt_out(fx));
  acb_lane u_lane_y (.clk, .rst, .ctl, .cal_row(cal_y), .coeffs(co_y),
                     .raw_x, .raw_y, .raw_z, .filt_out(fy));
  acb_lane u_lane_z (.clk, .rst, .ctl, .cal_row(cal_z), .coeffs(co_z),
                     .raw_x, .raw_y, .raw_z, .filt_out(fz));

  // pitch uses x over the y-z magnitude, roll uses -y over x-z
  always_comb begin
    if (state == S_ROLL) begin
      t_num = -17'(fy);
      t_a   = fx;
    end else begin
      t_num = 17'(fx);
      t_a   = fy;
    end
    t_b = fz;
  end

  assign tilt_start = (state == S_PITCH || state == S_ROLL) && !wait_tilt;

  acb_tilt u_tilt (.clk, .rst, .start(tilt_start), .num(t_num), .a(t_a), .b(t_b),
                   .busy(tilt_busy), .done(tilt_done), .angle(t_angle));

  assign load_out = (state == S_HOLD) && (!angles.valid || angles.ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (samples.valid && samples.new_data_flags != 4'd0) state_next = S_LANE;
      S_LANE:  if (step == STEP_FILT) state_next = last ? S_PITCH : S_IDLE;
      S_PITCH: if (tilt_done) state_next = S_ROLL;
      S_ROLL:  if (tilt_done) state_next = S_HOLD;
      S_HOLD:  if (load_out) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      step         <= '0;
      wait_tilt    <= 1'b0;
      angles.valid <= 1'b0;
    end else begin
      if (load_out) angles.valid <= 1'b1;
      else if (angles.valid && angles.ready) angles.valid <= 1'b0;
      case (state)
        S_IDLE: if (samples.valid) begin
          raw_x <= samples.raw_x;
          raw_y <= samples.raw_y;
          raw_z <= samples.raw_z;
          step  <= '0;
        end
        S_LANE: begin
          step <= step + STEP_W'(1);
          if (step == STEP_FILT) cnt <= last ? '0 : cnt + CNT_W'(1);
        end
        S_PITCH, S_ROLL: begin
          if (tilt_start) wait_tilt <= 1'b1;
          if (tilt_done) begin
            wait_tilt <= 1'b0;
            if (state == S_PITCH) pitch_r <= t_angle;
            else roll_r <= t_angle;
          end
        end
        S_HOLD: if (load_out) begin
          angles.pitch_deg <= pitch_r;
          angles.roll_deg  <= roll_r;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_after_tilt, $rose(angles.valid), $past(state) == S_HOLD, "result loaded outside hold")
  `ASSERT_IMPL(a_cnt_wrap, state == S_LANE && step == STEP_FILT && last, ##1 cnt == '0, "block count did not clear")
  `ASSERT_IMPL(a_tilt_idle_on_accept, samples.ready, !tilt_busy, "merge stage busy while taking samples")
endmodule
`default_nettype wire

// ----- rtl/acb_lane.sv -----
// One axis lane: calibration and running biquad over the block, at most one MAC per step.
// Depends on acb_pkg.
`default_nettype none
module acb_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  acb_pkg::lane_ctl_t       ctl,
  input  logic [63:0]              cal_row,
  input  logic [59:0]              coeffs,
  input  logic signed [15:0]       raw_x,
  input  logic signed [15:0]       raw_y,
  input  logic signed [15:0]       raw_z,
  output logic signed [15:0]       filt_out
);
  import acb_pkg::*;

  logic signed [35:0] acc;
  logic signed [15:0] xn, x1, x2, y1, y2;
  logic signed [15:0] op_a, op_b;
  logic signed [31:0] prod;
  logic signed [35:0] cal_q, filt_q;
  logic signed [15:0] y_new;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (ctl.step) inside
      STEP_GX: begin op_a = cal_row[15:0];  op_b = raw_x; end
      STEP_GY: begin op_a = cal_row[31:16]; op_b = raw_y; end
      STEP_GZ: begin op_a = cal_row[47:32]; op_b = raw_z; end
      STEP_B0: begin op_a = {{4{coeffs[11]}}, coeffs[11:0]};  op_b = xn; end
      STEP_B1: begin op_a = {{4{coeffs[23]}}, coeffs[23:12]}; op_b = x1; end
      STEP_A1: begin op_a = {{4{coeffs[47]}}, coeffs[47:36]}; op_b = y1; end
      STEP_B2: begin op_a = {{4{coeffs[35]}}, coeffs[35:24]}; op_b = x2; end
      STEP_A2: begin op_a = {{4{coeffs[59]}}, coeffs[59:48]}; op_b = y2; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod   = op_a * op_b;
  // offset joins the sum, then round half up from 2^-20 to Q4.12
  assign cal_q  = (acc + 36'(signed'(cal_row[63:48])) + 36'sd128) >>> 8;
  assign filt_q = (acc + 36'sd512) >>> 10;
  assign y_new  = sat16(filt_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      x1 <= '0;
      x2 <= '0;
      y1 <= '0;
      y2 <= '0;
    end else if (ctl.run) begin
      case (ctl.step) inside
        STEP_GX, STEP_B0: acc <= 36'(prod);
        STEP_GY, STEP_GZ, STEP_B1, STEP_A1, STEP_B2, STEP_A2: acc <= acc + 36'(prod);
        STEP_CAL: xn <= sat16(cal_q);
        STEP_FILT: begin
          if (ctl.last) begin
            // next block starts from zero history
            filt_out <= y_new;
            x1 <= '0;
            x2 <= '0;
            y1 <= '0;
            y2 <= '0;
          end else begin
            x2 <= x1;
            x1 <= xn;
            y2 <= y1;
            y1 <= y_new;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/acb_tilt.sv -----
// Merge stage: angle of num over sqrt(a^2 + b^2), via bit-serial isqrt and CORDIC.
// Depends on acb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module acb_tilt (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] num,
  input  logic signed [15:0] a,
  input  logic signed [15:0] b,
  output logic               busy,
  output logic               done,
  output logic signed [14:0] angle
);
  import acb_pkg::*;

  tilt_state_t state, state_next;
  logic signed [16:0] num_r;
  logic signed [15:0] a_r, b_r;
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_prod;
  logic [31:0] sq;
  logic [47:0] rem, root, bitv, trial;
  logic [4:0]  k, i;
  logic signed [27:0] cx, cy, dx, dy;
  logic signed [24:0] z, zr;

  assign sq_op   = (state == T_SQA) ? a_r : b_r;
  assign sq_prod = sq_op * sq_op;
  assign bitv    = 48'(1) << {k, 1'b0};
  assign trial   = root + bitv;
  assign dx      = cy >>> i;
  assign dy      = cx >>> i;
  assign zr      = (z + 25'sd256) >>> 9;
  assign busy    = (state != T_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: if (start && num != '0) state_next = T_SQA;
      T_SQA:  state_next = T_SQB;
      T_SQB:  state_next = T_SQRT;
      T_SQRT: if (k == '0) state_next = T_CHK;
      T_CHK:  state_next = (root == '0) ? T_IDLE : T_COR;
      T_COR:  if (i == 5'(CORDIC_STEPS - 1)) state_next = T_FIN;
      T_FIN:  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= T_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        T_IDLE: if (start) begin
          num_r <= num;
          a_r   <= a;
          b_r   <= b;
          if (num == '0) begin
            angle <= '0;
            done  <= 1'b1;
          end
        end
        T_SQA: sq <= 32'(sq_prod);
        T_SQB: begin
          rem  <= {sq + 32'(sq_prod), 16'b0};
          root <= '0;
          k    <= 5'(SQRT_STEPS - 1);
        end
        T_SQRT: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          k <= k - 5'd1;
        end
        T_CHK: begin
          if (root == '0) begin
            angle <= num_r[16] ? -15'sd11520 : 15'sd11520;
            done  <= 1'b1;
          end
          cx <= 28'(root[23:0]);
          cy <= {{3{num_r[16]}}, num_r, 8'b0};
          z  <= '0;
          i  <= '0;
        end
        T_COR: begin
          if (cy > 28'sd0) begin
            cx <= cx + dx;
            cy <= cy - dy;
            z  <= z + atan_entry(i);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            z  <= z - atan_entry(i);
          end
          i <= i + 5'd1;
        end
        T_FIN: begin
          if (zr > 25'sd11520) angle <= 15'sd11520;
          else if (zr < -25'sd11520) angle <= -15'sd11520;
          else angle <= zr[14:0];
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_done_from_work, done, $past(state) == T_FIN || $past(state) == T_CHK || $past(state) == T_IDLE, "tilt done from wrong state")
  `ASSERT_IMPL(a_sqrt_count, state == T_SQB, state_next == T_SQRT, "square stage must lead into root")
  `ASSERT_IMPL(a_angle_range, done, angle <= 15'sd11520 && angle >= -15'sd11520, "angle out of range")
endmodule
`default_nettype wire

// ----- tb/accel_tilt_block_filter_test.sv -----
// Self-checking testbench for the accelerometer tilt block filter.
// Depends on acb_pkg, acb_intf and the accel_tilt_block_filter RTL.
`default_nettype none
module accel_tilt_block_filter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import acb_pkg::*;

  localparam int BLK = 4;
  localparam int ANG_MAX = 11520;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [3:0]         flags;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic signed [15:0] rz;
  } sample_t;

  typedef struct packed {
    logic signed [14:0] pitch;
    logic signed [14:0] roll;
  } tilt_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  acb_in_if samples ();
  acb_out_if angles ();

  accel_tilt_block_filter #(.BLOCK_LEN(BLK)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .samples(samples.sink), .angles(angles.source)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [63:0] cal_row [3];
  logic [59:0] coeff_row [3];
  longint store [3][BLK];
  int fill;

  sample_t pending [$];
  tilt_t expected_tilts [$];
  int errors = 0;
  longint cycles = 0;

  localparam longint ATAN_TAB [17] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};

  function automatic longint sx(logic [63:0] v, int w);
    logic [63:0] m;
    m = 64'd1 << (w - 1);
    v &= (m << 1) - 1;
    return longint'(v ^ m) - longint'(m);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint calibrated(logic [63:0] row, longint x, longint y, longint z);
    longint acc;
    acc = sx(row, 16) * x + sx(row >> 16, 16) * y + sx(row >> 32, 16) * z
        + sx(row >> 48, 16);
    return clip((acc + 128) >>> 8, -32768, 32767);
  endfunction

  function automatic longint biquad_last(int ax, logic [59:0] c);
    longint b0, b1, b2, a1, a2, x1, x2, y1, y2, y, s;
    b0 = sx(c, 12); b1 = sx(c >> 12, 12); b2 = sx(c >> 24, 12);
    a1 = sx(c >> 36, 12); a2 = sx(c >> 48, 12);
    x1 = 0; x2 = 0; y1 = 0; y2 = 0; y = 0;
    for (int n = 0; n < BLK; n++) begin
      s = b0 * store[ax][n] + b1 * x1 + a1 * y1 + b2 * x2 + a2 * y2;
      y = clip((s + 512) >>> 10, -32768, 32767);
      x2 = x1; x1 = store[ax][n];
      y2 = y1; y1 = y;
    end
    return y;
  endfunction

  function automatic longint int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint angle_of(longint num, longint a, longint b);
    longint x, y, z, dx, dy;
    logic [63:0] sq;
    if (num == 0) return 0;
    sq = a * a + b * b;
    x = int_sqrt(sq << 16);
    if (x == 0) return num > 0 ? ANG_MAX : -ANG_MAX;
    y = num * 256; z = 0;
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i; dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end
    end
    return clip((z + 256) >>> 9, -ANG_MAX, ANG_MAX);
  endfunction

  task automatic predict_tilt(sample_t s);
    longint fx, fy, fz;
    tilt_t t;
    if (s.flags == 4'd0) return;
    if (fill >= BLK) fill = 0;
    for (int a = 0; a < 3; a++) store[a][fill] = calibrated(cal_row[a], s.rx, s.ry, s.rz);
    fill++;
    if (fill < BLK) return;
    fx = biquad_last(0, coeff_row[0]);
    fy = biquad_last(1, coeff_row[1]);
    fz = biquad_last(2, coeff_row[2]);
    fill = 0;
    t.pitch = 15'(angle_of(fx, fy, fz));
    t.roll = 15'(angle_of(-fy, fx, fz));
    expected_tilts.push_back(t);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int in_gap = 0;
  bit hold_off = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
    end else begin
      if (samples.valid && samples.ready) begin
        predict_tilt({samples.new_data_flags, samples.raw_x, samples.raw_y, samples.raw_z});
        in_gap = gap_len();
      end
      if ((samples.valid && !samples.ready) ) begin
        // hold current transaction
      end else if (in_gap > 0 || hold_off || pending.size() == 0) begin
        if (in_gap > 0) in_gap--;
        samples.valid <= 1'b0;
      end else begin
        sample_t s;
        s = pending.pop_front();
        samples.valid <= 1'b1;
        samples.new_data_flags <= s.flags;
        samples.raw_x <= s.rx;
        samples.raw_y <= s.ry;
        samples.raw_z <= s.rz;
      end
    end
  end

  // monitor
  int out_gap = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
    if (rst) begin
      angles.ready <= 1'b0;
    end else begin
      if (angles.valid && angles.ready) begin
        if (expected_tilts.size() == 0) begin
          $display("%0t: unexpected result pitch=%0d roll=%0d", $time,
                   angles.pitch_deg, angles.roll_deg);
          errors++;
        end else begin
          tilt_t e;
          e = expected_tilts.pop_front();
          if (e.pitch !== angles.pitch_deg) begin
            $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, angles.pitch_deg);
            errors++;
          end
          if (e.roll !== angles.roll_deg) begin
            $display("%0t: roll expected %0d actual %0d", $time, e.roll, angles.roll_deg);
            errors++;
          end
        end
        out_gap = gap_len();
      end
      if (out_gap > 0) begin
        out_gap--;
        angles.ready <= 1'b0;
      end else angles.ready <= 1'b1;
    end
  end

  initial begin
    samples.valid = 1'b0;
    samples.new_data_flags = '0;
    samples.raw_x = '0;
    samples.raw_y = '0;
    samples.raw_z = '0;
    angles.ready = 1'b0;
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CAL_X) cal_row[0] = val;
    else if (idx == REG_CAL_Y) cal_row[1] = val;
    else if (idx == REG_CAL_Z) cal_row[2] = val;
    else if (idx == REG_FILT_X) coeff_row[0] = val[59:0];
    else if (idx == REG_FILT_Y) coeff_row[1] = val[59:0];
    else if (idx == REG_FILT_Z) coeff_row[2] = val[59:0];
  endtask

  // wait for the queue to drain and the block to go quiet on a block boundary;
  // a part-filled block is topped up with flagged samples
  task automatic drain();
    do begin
      if (fill != 0) pending.push_back(rand_sample(1'b0));
      while (pending.size() != 0 || samples.valid || expected_tilts.size() != 0)
        @(posedge clk);
      repeat (300) @(posedge clk);
    end while (fill != 0);
  endtask

  function automatic logic [11:0] q210(real v);
    return 12'($rtoi(v * 1024.0));
  endfunction

  // setting 0: unity-ish cal, mild low pass; 4: b0 = 1; others random/extreme
  task automatic configure(int kind);
    logic [63:0] r [3];
    logic [59:0] c;
    for (int a = 0; a < 3; a++) begin
      case (kind)
        0: r[a] = {16'sd0, (a == 2) ? 16'sd4096 : 16'sd0,
                   (a == 1) ? 16'sd4096 : 16'sd0, (a == 0) ? 16'sd4096 : 16'sd0};
        1: r[a] = 64'hFFFF_FFFF_FFFF_FFFF;
        2: r[a] = 64'h7FFF_7FFF_7FFF_7FFF;
        3: r[a] = 64'h8000_8000_8000_8000;
        default: r[a] = {$urandom, $urandom};
      endcase
      write_reg(3'(a), r[a]);
    end
    for (int a = 0; a < 3; a++) begin
      case (kind)
        0: c = {q210(-0.2430), q210(0.2951), q210(0.2427), q210(0.4853), q210(0.2427)};
        1: c = '1;
        2: c = {12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF, 12'h7FF};
        3: c = {12'h800, 12'h800, 12'h800, 12'h800, 12'h800};
        4: c = {12'd0, 12'd0, 12'd0, 12'd0, 12'd1024};
        default: c = 60'({$urandom, $urandom});
      endcase
      write_reg(3'(REG_FILT_X + a), {4'(kind), c});
    end
  endtask

  function automatic sample_t rand_sample(bit allow_zero);
    sample_t s;
    int m;
    s.flags = allow_zero && $urandom_range(0, 9) == 0 ? 4'd0 : 4'($urandom_range(1, 15));
    m = $urandom_range(0, 3);
    s.rx = (m == 0) ? 16'($urandom_range(0, 1) ? 32767 : -32768) : 16'($urandom);
    s.ry = (m == 1) ? 16'sd0 : 16'($urandom);
    s.rz = (m == 2) ? 16'($urandom_range(0, 255) - 128) : 16'($urandom);
    return s;
  endfunction

  initial begin
    for (int a = 0; a < 3; a++) begin
      cal_row[a] = '0; coeff_row[a] = '0;
      for (int n = 0; n < BLK; n++) store[a][n] = 0;
    end
    fill = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // write to an unknown register index must be ignored
    write_reg(3'd7, 64'hDEAD_BEEF_0123_4567);
    configure(0);
    // directed: extremes, zero flags, zero numerators and denominators
    pending.push_back('{4'd1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF});
    pending.push_back('{4'd0, 16'sh1234, 16'sh4321, 16'sh1111});
    pending.push_back('{4'd15, -16'sd32768, -16'sd32768, -16'sd32768});
    pending.push_back('{4'd8, 16'sd0, 16'sd0, 16'sd0});
    pending.push_back('{4'd2, 16'sd0, 16'sd0, 16'sd0});
    for (int i = 0; i < 4; i++) pending.push_back('{4'd4, 16'sd0, 16'sd0, 16'sd0});
    for (int i = 0; i < 4; i++) pending.push_back('{4'd3, 16'sd8000, 16'sd0, 16'sd0});
    for (int i = 0; i < 4; i++) pending.push_back('{4'd5, 16'sd0, -16'sd8000, 16'sd0});
    for (int i = 0; i < 4; i++) pending.push_back('{4'd9, 16'sd3000, 16'sd2000, 16'sd4000});
    drain();
    for (int phase = 1; phase <= 7; phase++) begin
      configure(phase == 7 ? 0 : phase);
      for (int i = 0; i < 270; i++) pending.push_back(rand_sample(1'b1));
      // sender pauses once until every result is back
      if (phase == 4) begin
        while (pending.size() > 130) @(posedge clk);
        hold_off = 1'b1;
        while (samples.valid || expected_tilts.size() != 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/acb_pkg.sv
rtl/acb_intf.sv
rtl/acb_lane.sv
rtl/acb_tilt.sv
rtl/accel_tilt_block_filter.sv
tb/accel_tilt_block_filter_test.sv
